// ----- hdl/cosg_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// cosg_pkg: shared definitions for the circular orbit state generator
// Register map indexes, CORDIC constants, angle table and saturation helper.
// ----------------------------------------------------------------------------
package cosg_pkg;

  localparam int DEF_ROTATION_STAGES    = 24;
  localparam int DEF_TRIG_FRACTION_BITS = 30;

  localparam int CFG_AW    = 6;
  localparam int CFG_DW    = 64;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_AT_EPOCH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_RATE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORBIT_RADIUS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ORBIT_SPEED    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INCL_COS       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INCL_SIN       = 3'd5;

  localparam logic signed [31:0] INCL_COS_RESET = 32'sd1073741824;

  // CORDIC gain with 62 fraction bits
  localparam logic [63:0] GAIN_Q62 = 64'd2800459870029452953;

  // Arctangent of 2^-i in units of 2^-32 turn, truncated
  function automatic logic [31:0] atan_turn(input int idx);
    logic [31:0] a;
    case (idx)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2F9;
      15: a = 32'h0000517C;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A2F;
      19: a = 32'h00000517;
      20: a = 32'h0000028B;
      21: a = 32'h00000145;
      22: a = 32'h000000A2;
      23: a = 32'h00000051;
      24: a = 32'h00000028;
      25: a = 32'h00000014;
      26: a = 32'h0000000A;
      27: a = 32'h00000005;
      28: a = 32'h00000002;
      29: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  // Saturate a sign-magnitude value to the signed 32 bit range
  function automatic logic [31:0] sat_sm(input logic neg, input logic [35:0] mag);
    logic [31:0] v;
    if (neg) begin
      if (mag > 36'h080000000) v = 32'h80000000;
      else                     v = 32'd0 - mag[31:0];
    end else begin
      if (mag > 36'h07FFFFFFF) v = 32'h7FFFFFFF;
      else                     v = mag[31:0];
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/circular_orbit_state_generator_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// circular_orbit_state_generator_core: circular orbit position and velocity
// Maps a signed elapsed time to inertial position and velocity on a tilted
// circular orbit through a binary-turn phase and a pipelined CORDIC.
// ----------------------------------------------------------------------------
// Send one request (start with in_elapsed_time) in any cycle: busy stays low,
// so a new request is taken every clock. Each request yields exactly one
// result, shown for a single cycle with out_valid; results come out in
// request order. The receiver cannot stall: capture the result in the cycle
// out_valid is high. Each request passes through the rotation unit, one
// CORDIC stage per register, plus two phase stages and five scaling and
// saturation stages. Write the configuration registers (64 bit APB,
// register i at byte 8*i) only while no request is in flight.
// ----------------------------------------------------------------------------
module circular_orbit_state_generator_core
  import cosg_pkg::*;
#(
  parameter int ROTATION_STAGES    = DEF_ROTATION_STAGES,
  parameter int TRIG_FRACTION_BITS = DEF_TRIG_FRACTION_BITS
) (
  input  wire  logic                clk,
  input  wire  logic                rst_n,
  input  wire  logic                psel,
  input  wire  logic                penable,
  input  wire  logic                pwrite,
  input  wire  logic [CFG_AW-1:0]   paddr,
  input  wire  logic [CFG_DW-1:0]   pwdata,
  output logic       [CFG_DW-1:0]   prdata,
  output logic                      pready,
  input  wire  logic                start,
  output logic                      busy,
  input  wire  logic signed [39:0]  in_elapsed_time,
  output logic                      out_valid,
  output logic signed [31:0]        out_pos_x,
  output logic signed [31:0]        out_pos_y,
  output logic signed [31:0]        out_pos_z,
  output logic signed [31:0]        out_vel_x,
  output logic signed [31:0]        out_vel_y,
  output logic signed [31:0]        out_vel_z,
  output logic signed [39:0]        out_time_echo
);

  localparam int N    = ROTATION_STAGES;
  localparam int F    = TRIG_FRACTION_BITS;
  localparam int XW   = F + 3;                 // CORDIC x/y width
  localparam int ZW   = 33;                    // residual angle width
  localparam int UW   = F + 2;                 // trig magnitude width
  localparam int UPW  = (UW > 32) ? UW : 33;   // padded magnitude width
  localparam int HW   = UPW - 32;              // high part of magnitude
  localparam int PLW  = 63;
  localparam int PHW  = 31 + HW;
  localparam int SUMW = 31 + UPW + 1;
  localparam int RW   = 34;                    // scaled magnitude width
  localparam int TW   = RW + 32;               // tilt product width
  localparam int LAT  = N + 7;

  localparam logic [63:0]          GAIN_SH = GAIN_Q62 >> (62 - F);
  localparam logic signed [XW-1:0] GAIN_K  = signed'(XW'(GAIN_SH));

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [31:0]        phase_epoch_r;
  logic [47:0]        phase_rate_r;
  logic [30:0]        orbit_radius_r;
  logic [30:0]        orbit_speed_r;
  logic signed [31:0] incl_cos_r;
  logic signed [31:0] incl_sin_r;

  logic                 cfg_wr;
  logic [CFG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[CFG_AW-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_epoch_r  <= '0;
      phase_rate_r   <= '0;
      orbit_radius_r <= '0;
      orbit_speed_r  <= '0;
      incl_cos_r     <= INCL_COS_RESET;
      incl_sin_r     <= '0;
    end else if (cfg_wr) begin
      // drop writes to unmapped indexes
      unique case (cfg_idx)
        REG_PHASE_AT_EPOCH: phase_epoch_r  <= pwdata[31:0];
        REG_PHASE_RATE:     phase_rate_r   <= pwdata[47:0];
        REG_ORBIT_RADIUS:   orbit_radius_r <= pwdata[30:0];
        REG_ORBIT_SPEED:    orbit_speed_r  <= pwdata[30:0];
        REG_INCL_COS:       incl_cos_r     <= signed'(pwdata[31:0]);
        REG_INCL_SIN:       incl_sin_r     <= signed'(pwdata[31:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_PHASE_AT_EPOCH: prdata = {32'd0, phase_epoch_r};
      REG_PHASE_RATE:     prdata = {16'd0, phase_rate_r};
      REG_ORBIT_RADIUS:   prdata = {33'd0, orbit_radius_r};
      REG_ORBIT_SPEED:    prdata = {33'd0, orbit_speed_r};
      REG_INCL_COS:       prdata = {{32{incl_cos_r[31]}}, incl_cos_r};
      REG_INCL_SIN:       prdata = {{32{incl_sin_r[31]}}, incl_sin_r};
      default:            prdata = '0;
    endcase
  end

  // The pipeline never stalls, so a request is taken every cycle
  assign busy = 1'b0;

  logic req_acc;
  assign req_acc = start && !busy;

  // --------------------------------------------------------------------------
  // Stage A: partial products of rate times time, modulo 2^64
  //   rate = rh*2^32 + rl, time = th*2^32 + tl (th signed)
  // --------------------------------------------------------------------------
  logic [31:0] rl, tl, prod_lh;
  logic [15:0] rh;
  logic [7:0]  th;
  logic [47:0] prod_hl;

  assign rl      = phase_rate_r[31:0];
  assign rh      = phase_rate_r[47:32];
  assign tl      = in_elapsed_time[31:0];
  assign th      = in_elapsed_time[39:32];
  assign prod_hl = 48'(rh) * 48'(tl);
  assign prod_lh = rl * {{24{th[7]}}, th};

  logic               a_v_r;
  logic [63:0]        a_ll_r;
  logic [31:0]        a_hl_r;
  logic [31:0]        a_lh_r;
  logic signed [39:0] a_t_r;

  always_ff @(posedge clk) begin
    a_ll_r <= 64'(rl) * 64'(tl);
    a_hl_r <= prod_hl[31:0];
    a_lh_r <= prod_lh;
    a_t_r  <= in_elapsed_time;
  end

  // --------------------------------------------------------------------------
  // Stage B: phase in 2^-32 turn, then the CORDIC rotation pipeline
  // --------------------------------------------------------------------------
  logic [31:0] phase;
  assign phase = phase_epoch_r + a_ll_r[63:32] + a_hl_r + a_lh_r;

  logic signed [XW-1:0] cx_r [0:N];
  logic signed [XW-1:0] cy_r [0:N];
  logic signed [ZW-1:0] cz_r [0:N];
  logic [1:0]           cq_r [0:N];
  logic signed [39:0]   ct_r [0:N];
  logic                 cv_r [0:N];

  always_ff @(posedge clk) begin
    cx_r[0] <= GAIN_K;
    cy_r[0] <= '0;
    cz_r[0] <= signed'(ZW'(phase[29:0]));
    cq_r[0] <= phase[31:30];
    ct_r[0] <= a_t_r;
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic signed [ZW-1:0] ANG = signed'({1'b0, atan_turn(i)});
    always_ff @(posedge clk) begin
      // rotate toward zero residual angle
      if (cz_r[i][ZW-1]) begin
        cx_r[i+1] <= cx_r[i] + (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] - (cx_r[i] >>> i);
        cz_r[i+1] <= cz_r[i] + ANG;
      end else begin
        cx_r[i+1] <= cx_r[i] - (cy_r[i] >>> i);
        cy_r[i+1] <= cy_r[i] + (cx_r[i] >>> i);
        cz_r[i+1] <= cz_r[i] - ANG;
      end
      cq_r[i+1] <= cq_r[i];
      ct_r[i+1] <= ct_r[i];
    end
  end

  // --------------------------------------------------------------------------
  // Stage Q: quadrant mapping into sign-magnitude cosine and sine
  // --------------------------------------------------------------------------
  logic [UW-1:0] mag_x, mag_y;
  logic          neg_x, neg_y;
  logic [UW-1:0] c_mag, s_mag;
  logic          c_neg, s_neg;

  assign neg_x = cx_r[N][XW-1];
  assign neg_y = cy_r[N][XW-1];
  assign mag_x = neg_x ? UW'(-cx_r[N]) : UW'(cx_r[N]);
  assign mag_y = neg_y ? UW'(-cy_r[N]) : UW'(cy_r[N]);

  always_comb begin
    unique case (cq_r[N])
      2'd0: begin
        c_mag = mag_x; c_neg = neg_x;  s_mag = mag_y; s_neg = neg_y;
      end
      2'd1: begin
        c_mag = mag_y; c_neg = !neg_y; s_mag = mag_x; s_neg = neg_x;
      end
      2'd2: begin
        c_mag = mag_x; c_neg = !neg_x; s_mag = mag_y; s_neg = !neg_y;
      end
      default: begin
        c_mag = mag_y; c_neg = neg_y;  s_mag = mag_x; s_neg = !neg_x;
      end
    endcase
  end

  logic               q_v_r;
  logic [UPW-1:0]     q_c_r, q_s_r;
  logic               q_cn_r, q_sn_r;
  logic signed [39:0] q_t_r;

  always_ff @(posedge clk) begin
    q_c_r  <= UPW'(c_mag);
    q_s_r  <= UPW'(s_mag);
    q_cn_r <= c_neg;
    q_sn_r <= s_neg;
    q_t_r  <= ct_r[N];
  end

  // --------------------------------------------------------------------------
  // Stage M: radius and speed times cosine and sine, in two partial products
  // --------------------------------------------------------------------------
  logic               m_v_r;
  logic [PLW-1:0]     m_rc_lo_r, m_rs_lo_r, m_vc_lo_r, m_vs_lo_r;
  logic [PHW-1:0]     m_rc_hi_r, m_rs_hi_r, m_vc_hi_r, m_vs_hi_r;
  logic               m_cn_r, m_sn_r;
  logic signed [39:0] m_t_r;

  always_ff @(posedge clk) begin
    m_rc_lo_r <= PLW'(orbit_radius_r) * PLW'(q_c_r[31:0]);
    m_rs_lo_r <= PLW'(orbit_radius_r) * PLW'(q_s_r[31:0]);
    m_vc_lo_r <= PLW'(orbit_speed_r)  * PLW'(q_c_r[31:0]);
    m_vs_lo_r <= PLW'(orbit_speed_r)  * PLW'(q_s_r[31:0]);
    m_rc_hi_r <= PHW'(orbit_radius_r) * PHW'(q_c_r[UPW-1:32]);
    m_rs_hi_r <= PHW'(orbit_radius_r) * PHW'(q_s_r[UPW-1:32]);
    m_vc_hi_r <= PHW'(orbit_speed_r)  * PHW'(q_c_r[UPW-1:32]);
    m_vs_hi_r <= PHW'(orbit_speed_r)  * PHW'(q_s_r[UPW-1:32]);
    m_cn_r    <= q_cn_r;
    m_sn_r    <= q_sn_r;
    m_t_r     <= q_t_r;
  end

  // --------------------------------------------------------------------------
  // Stage R: combine, round half away from zero, shift by the trig fraction
  // --------------------------------------------------------------------------
  localparam logic [SUMW-1:0] RND_F = SUMW'(1) << (F - 1);

  function automatic logic [RW-1:0] round_f(input logic [PLW-1:0] lo,
                                            input logic [PHW-1:0] hi);
    logic [SUMW-1:0] s;
    s = SUMW'(lo) + (SUMW'(hi) << 32) + RND_F;
    return RW'(s >> F);
  endfunction

  logic               r_v_r;
  logic [RW-1:0]      r_x_r, r_y_r, r_vx_r, r_vy_r;
  logic               r_xn_r, r_yn_r, r_vxn_r, r_vyn_r;
  logic signed [39:0] r_t_r;

  always_ff @(posedge clk) begin
    r_x_r   <= round_f(m_rc_lo_r, m_rc_hi_r);
    r_y_r   <= round_f(m_rs_lo_r, m_rs_hi_r);
    r_vx_r  <= round_f(m_vs_lo_r, m_vs_hi_r);
    r_vy_r  <= round_f(m_vc_lo_r, m_vc_hi_r);
    r_xn_r  <= m_cn_r;
    r_yn_r  <= m_sn_r;
    r_vxn_r <= !m_sn_r;   // velocity x is minus speed times sine
    r_vyn_r <= m_cn_r;
    r_t_r   <= m_t_r;
  end

  // --------------------------------------------------------------------------
  // Stage T: tilt the in-plane y terms by the inclination
  // --------------------------------------------------------------------------
  logic [31:0] ic_mag, is_mag;
  assign ic_mag = incl_cos_r[31] ? 32'd0 - incl_cos_r : incl_cos_r;
  assign is_mag = incl_sin_r[31] ? 32'd0 - incl_sin_r : incl_sin_r;

  logic               t_v_r;
  logic [TW-1:0]      t_yc_r, t_ys_r, t_vc_r, t_vs_r;
  logic               t_ycn_r, t_ysn_r, t_vcn_r, t_vsn_r;
  logic [RW-1:0]      t_x_r, t_vx_r;
  logic               t_xn_r, t_vxn_r;
  logic signed [39:0] t_t_r;

  always_ff @(posedge clk) begin
    t_yc_r  <= TW'(r_y_r)  * TW'(ic_mag);
    t_ys_r  <= TW'(r_y_r)  * TW'(is_mag);
    t_vc_r  <= TW'(r_vy_r) * TW'(ic_mag);
    t_vs_r  <= TW'(r_vy_r) * TW'(is_mag);
    t_ycn_r <= r_yn_r  ^ incl_cos_r[31];
    t_ysn_r <= r_yn_r  ^ incl_sin_r[31];
    t_vcn_r <= r_vyn_r ^ incl_cos_r[31];
    t_vsn_r <= r_vyn_r ^ incl_sin_r[31];
    t_x_r   <= r_x_r;
    t_xn_r  <= r_xn_r;
    t_vx_r  <= r_vx_r;
    t_vxn_r <= r_vxn_r;
    t_t_r   <= r_t_r;
  end

  // --------------------------------------------------------------------------
  // Stage O: round the Q1.30 products, saturate, drive the result ports
  // --------------------------------------------------------------------------
  function automatic logic [35:0] round_30(input logic [TW-1:0] p);
    logic [TW:0] s;
    s = (TW+1)'(p) + (TW+1)'(32'h20000000);
    return 36'(s >> 30);
  endfunction

  logic out_valid_r;

  always_ff @(posedge clk) begin
    out_pos_x     <= signed'(sat_sm(t_xn_r,  36'(t_x_r)));
    out_pos_y     <= signed'(sat_sm(t_ycn_r, round_30(t_yc_r)));
    out_pos_z     <= signed'(sat_sm(t_ysn_r, round_30(t_ys_r)));
    out_vel_x     <= signed'(sat_sm(t_vxn_r, 36'(t_vx_r)));
    out_vel_y     <= signed'(sat_sm(t_vcn_r, round_30(t_vc_r)));
    out_vel_z     <= signed'(sat_sm(t_vsn_r, round_30(t_vs_r)));
    out_time_echo <= t_t_r;
  end

  // --------------------------------------------------------------------------
  // Valid chain: advance one stage per clock, clear on reset
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= 1'b0;
      q_v_r       <= 1'b0;
      m_v_r       <= 1'b0;
      r_v_r       <= 1'b0;
      t_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k <= N; k++) cv_r[k] <= 1'b0;
    end else begin
      a_v_r   <= req_acc;
      cv_r[0] <= a_v_r;
      for (int k = 0; k < N; k++) cv_r[k+1] <= cv_r[k];
      q_v_r       <= cv_r[N];
      m_v_r       <= q_v_r;
      r_v_r       <= m_v_r;
      t_v_r       <= r_v_r;
      out_valid_r <= t_v_r;
    end
  end

  assign out_valid = out_valid_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    req_acc |-> ##LAT out_valid)
    else $error("request did not produce a result after the pipeline latency");

  a_time_echo : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_time_echo == $past(in_elapsed_time, LAT)))
    else $error("time echo does not match the request that produced it");

  a_reset_flush : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe high right after reset");

endmodule
`default_nettype wire
